FILE: rtl/chm_pkg.sv
package chm_pkg;

  localparam int MAX_BUCKETS_DEF = 1024;
  localparam int ANCHOR_RESET    = 1024;
  localparam int BUCKET_W        = 10;
  localparam int REG_W           = 11;
  localparam int REG_IDX_W       = 2;
  localparam int CMD_W           = 2;
  localparam int KEY_W           = 64;
  localparam int IN_TDATA_W      = 144;
  localparam int OUT_TDATA_W     = 16;
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_ADD    = 2'd2
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ANCHOR_COUNT    = 2'd0,
    REG_INITIAL_WORKING = 2'd1
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_CAP,
    OP_CRC,
    OP_MODI,
    OP_MOD,
    OP_HRD,
    OP_LRB,
    OP_DEC,
    OP_REH,
    OP_EDM,
    OP_ERK,
    OP_TDM,
    OP_TRK,
    OP_TCMP,
    OP_LOUT,
    OP_R1,
    OP_R2,
    OP_A1,
    OP_A2,
    OP_A3,
    OP_REJ
  } dp_op_e;

  typedef struct packed {
    logic             cfg_hit;
    logic             clr_last;
    logic             crc_last;
    logic             mod_last;
    logic             first;
    logic             rb_zero;
    logic             take;
    logic             same;
    logic             cont;
    logic             add_rej;
    logic             out_free;
    logic [CMD_W-1:0] cmd;
  } dp_status_t;

endpackage

FILE: rtl/consistent_hash_bucket_mapper.sv
// Lookup: the result follows the hash of the input beat when the first bucket is working
// (8 CRC byte steps, 32 modulo bit steps, table reads); each rehash repeats the hash,
// and each translation or diagonal step adds table reads.
// Remove and add read and then write the tables; a rejected add or an unknown command
// returns a set status bit without a table write; a stalled output holds the result back.
// One command is processed at a time; the next beat is taken once the result is registered.
// After reset and after every register write, a clearing pass over all MaxBuckets
// table addresses rebuilds the tables before the next input beat is taken.
module consistent_hash_bucket_mapper #(
  parameter int MaxBuckets = chm_pkg::MAX_BUCKETS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_high, key_low, target_bucket, zero padding
  input  logic [chm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd
  input  logic [chm_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // bucket, zero padding
  output logic [chm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status
  output logic                               m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [chm_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [chm_pkg::REG_W-1:0]          cfg_data_i
);
  import chm_pkg::*;

  dp_status_t          status;
  dp_op_e              op;
  logic [BUCKET_W-1:0] out_bucket;

  chm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i(status),
    .op_o(op)
  );

  chm_dp #(.MaxBuckets(MaxBuckets)) u_dp (
    .clk_i, .rst_ni,
    .op_i(op),
    .status_o(status),
    .in_cmd_i(s_axis_tuser),
    .in_key_high_i(s_axis_tdata[KEY_W-1:0]),
    .in_key_low_i(s_axis_tdata[2*KEY_W-1:KEY_W]),
    .in_target_i(s_axis_tdata[2*KEY_W+BUCKET_W-1:2*KEY_W]),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_bucket_o(out_bucket),
    .out_status_o(m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-BUCKET_W){1'b0}}, out_bucket};

endmodule

FILE: rtl/chm_ram.sv
module chm_ram #(
  parameter int Width = 10,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/chm_ctrl.sv
module chm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  chm_pkg::dp_status_t status_i,
  output chm_pkg::dp_op_e     op_o
);
  import chm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_CRC  = 5'd3;
  localparam logic [4:0] S_MODI = 5'd4;
  localparam logic [4:0] S_MOD  = 5'd5;
  localparam logic [4:0] S_HRD  = 5'd6;
  localparam logic [4:0] S_LRB  = 5'd7;
  localparam logic [4:0] S_CHK  = 5'd8;
  localparam logic [4:0] S_REH  = 5'd9;
  localparam logic [4:0] S_DEC  = 5'd10;
  localparam logic [4:0] S_EDM  = 5'd11;
  localparam logic [4:0] S_ERK  = 5'd12;
  localparam logic [4:0] S_TDM  = 5'd13;
  localparam logic [4:0] S_TRK  = 5'd14;
  localparam logic [4:0] S_TCMP = 5'd15;
  localparam logic [4:0] S_LOUT = 5'd16;
  localparam logic [4:0] S_R1   = 5'd17;
  localparam logic [4:0] S_R2   = 5'd18;
  localparam logic [4:0] S_A1   = 5'd19;
  localparam logic [4:0] S_A2   = 5'd20;
  localparam logic [4:0] S_A3   = 5'd21;
  localparam logic [4:0] S_BAD  = 5'd22;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NOP;
    in_ready_o = 1'b0;
    if (status_i.cfg_hit) begin
      state_d = S_CLR;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            op_o    = OP_CAP;
            state_d = S_DISP;
          end
        end
        S_CLR: begin
          op_o = OP_CLR;
          if (status_i.clr_last) state_d = S_IDLE;
        end
        S_DISP: begin
          unique case (status_i.cmd)
            CMD_LOOKUP: state_d = S_CRC;
            CMD_REMOVE: state_d = S_R1;
            CMD_ADD:    state_d = S_A1;
            default:    state_d = S_BAD;
          endcase
        end
        S_CRC: begin
          op_o = OP_CRC;
          if (status_i.crc_last) state_d = S_MODI;
        end
        S_MODI: begin
          op_o    = OP_MODI;
          state_d = S_MOD;
        end
        S_MOD: begin
          op_o = OP_MOD;
          if (status_i.mod_last) state_d = S_HRD;
        end
        S_HRD: begin
          op_o    = OP_HRD;
          state_d = status_i.first ? S_LRB : S_DEC;
        end
        S_LRB: begin
          op_o    = OP_LRB;
          state_d = S_CHK;
        end
        S_CHK: begin
          state_d = status_i.rb_zero ? S_LOUT : S_REH;
        end
        S_REH: begin
          op_o    = OP_REH;
          state_d = S_CRC;
        end
        S_DEC: begin
          op_o = OP_DEC;
          priority if (status_i.take) state_d = S_CHK;
          else if (status_i.same) state_d = S_EDM;
          else state_d = S_TDM;
        end
        S_EDM: begin
          op_o    = OP_EDM;
          state_d = S_ERK;
        end
        S_ERK: begin
          op_o    = OP_ERK;
          state_d = S_LRB;
        end
        S_TDM: begin
          op_o    = OP_TDM;
          state_d = S_TRK;
        end
        S_TRK: begin
          op_o    = OP_TRK;
          state_d = S_TCMP;
        end
        S_TCMP: begin
          op_o    = OP_TCMP;
          state_d = status_i.cont ? S_TDM : S_CHK;
        end
        S_LOUT: begin
          if (status_i.out_free) begin
            op_o    = OP_LOUT;
            state_d = S_IDLE;
          end
        end
        S_R1: begin
          op_o    = OP_R1;
          state_d = S_R2;
        end
        S_R2: begin
          if (status_i.out_free) begin
            op_o    = OP_R2;
            state_d = S_IDLE;
          end
        end
        S_A1: begin
          if (!status_i.add_rej) begin
            op_o    = OP_A1;
            state_d = S_A2;
          end else if (status_i.out_free) begin
            op_o    = OP_REJ;
            state_d = S_IDLE;
          end
        end
        S_A2: begin
          op_o    = OP_A2;
          state_d = S_A3;
        end
        S_A3: begin
          if (status_i.out_free) begin
            op_o    = OP_A3;
            state_d = S_IDLE;
          end
        end
        S_BAD: begin
          if (status_i.out_free) begin
            op_o    = OP_REJ;
            state_d = S_IDLE;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("Input taken outside idle.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && !status_i.cfg_hit && status_i.rb_zero) |=> state_q == S_LOUT)
    else $error("Working bucket did not end the lookup.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == OP_CAP) |-> in_valid_i)
    else $error("Capture without a beat.");

endmodule

FILE: rtl/chm_dp.sv
module chm_dp #(
  parameter int MaxBuckets = chm_pkg::MAX_BUCKETS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  chm_pkg::dp_op_e                 op_i,
  output chm_pkg::dp_status_t             status_o,
  input  logic [chm_pkg::CMD_W-1:0]       in_cmd_i,
  input  logic [chm_pkg::KEY_W-1:0]       in_key_high_i,
  input  logic [chm_pkg::KEY_W-1:0]       in_key_low_i,
  input  logic [chm_pkg::BUCKET_W-1:0]    in_target_i,
  input  logic                            cfg_we_i,
  input  logic [chm_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [chm_pkg::REG_W-1:0]       cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [chm_pkg::BUCKET_W-1:0]    out_bucket_o,
  output logic                            out_status_o
);
  import chm_pkg::*;

  localparam int AW = $clog2(MaxBuckets);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MaxBuckets);
  localparam logic [CW-1:0] AcReset =
    CW'((ANCHOR_RESET > MaxBuckets) ? MaxBuckets : ANCHOR_RESET);

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] x;
    x = c ^ {24'b0, d};
    for (int k = 0; k < 8; k++) begin
      x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
    end
    return x;
  endfunction

  function automatic logic [31:0] clamp(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    r = v;
    if (r < 32'd1) r = 32'd1;
    if (r > hi) r = hi;
    return r;
  endfunction

  logic [CW-1:0] ac_q, ac_d, iw_q, iw_d, wc_q, wc_d, sd_q, sd_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d, first_q, first_d;

  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [KEY_W-1:0]    kh_q, kh_d, kl_q, kl_d, data_q, data_d;
  logic [BUCKET_W-1:0] tgt_q, tgt_d, out_bucket_q, out_bucket_d;
  logic                out_status_q, out_status_d;
  logic [31:0]         crc_q, crc_d, hs_q, hs_d, div_q, div_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [CW-1:0]       rem_q, rem_d, dsr_q, dsr_d;
  logic [AW-1:0]       b_q, b_d, t_q, t_d, rb_q, rb_d;

  logic          rk_we, rk_re, wl_we, wl_re, lp_we, lp_re, dm_we, dm_re, st_we, st_re;
  logic [AW-1:0] rk_wa, rk_wd, rk_ra, rk_rd;
  logic [AW-1:0] wl_wa, wl_wd, wl_ra, wl_rd;
  logic [AW-1:0] lp_wa, lp_wd, lp_ra, lp_rd;
  logic [AW-1:0] dm_wa, dm_wd, dm_ra, dm_rd;
  logic [AW-1:0] st_wa, st_wd, st_ra, st_rd;

  logic          cfg_hit;
  logic [31:0]   ac_new, iw_new;
  logic [CW-1:0] clr_idx;
  logic [AW-1:0] rank_clr, stack_clr, lpb;
  logic [CW:0]   trial, diff;
  logic          rm_rej, add_rej, out_free;
  logic [63:0]   kl_sum, kh_dif;

  assign cfg_hit = cfg_we_i && (cfg_index_i == REG_ANCHOR_COUNT ||
                                cfg_index_i == REG_INITIAL_WORKING);
  assign ac_new  = (cfg_index_i == REG_ANCHOR_COUNT) ?
                   clamp(32'(cfg_data_i), 32'(MaxBuckets)) : 32'(ac_q);
  assign iw_new  = clamp((cfg_index_i == REG_INITIAL_WORKING) ? 32'(cfg_data_i) : 32'(iw_q),
                         ac_new);

  assign clr_idx   = {1'b0, clr_q};
  assign rank_clr  = (clr_idx >= iw_q && clr_idx < ac_q) ? clr_q : '0;
  assign stack_clr = (clr_idx < sd_q) ? AW'(ac_q - CW'(1) - clr_idx) : '0;

  assign trial = {rem_q, div_q[31]};
  assign diff  = trial - {1'b0, dsr_q};

  assign kl_sum = kl_q + {32'b0, hs_q};
  assign kh_dif = kh_q - {32'b0, hs_q};

  assign rm_rej  = (32'(tgt_q) >= 32'(ac_q)) || (rk_rd != '0) || (wc_q <= CW'(1)) ||
                   (sd_q >= MaxCnt);
  assign add_rej = (sd_q == '0) || (wc_q >= MaxCnt);
  assign lpb     = (wl_rd == b_q) ? AW'(wc_q) : lp_rd;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o          = '0;
    status_o.cfg_hit  = cfg_hit;
    status_o.clr_last = (clr_q == AW'(MaxBuckets - 1));
    status_o.crc_last = (cnt_q == 5'd7);
    status_o.mod_last = (cnt_q == 5'd31);
    status_o.first    = first_q;
    status_o.rb_zero  = (rb_q == '0);
    status_o.take     = (rk_rd == '0) || (rk_rd < rb_q);
    status_o.same     = (b_q == t_q);
    status_o.cont     = (rb_q <= rk_rd);
    status_o.add_rej  = add_rej;
    status_o.out_free = out_free;
    status_o.cmd      = cmd_q;
  end

  always_comb begin
    ac_d = ac_q;  iw_d = iw_q;  wc_d = wc_q;  sd_d = sd_q;  clr_d = clr_q;
    first_d = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_d = cmd_q;  kh_d = kh_q;  kl_d = kl_q;  tgt_d = tgt_q;
    data_d = data_q;  crc_d = crc_q;  hs_d = hs_q;  div_d = div_q;  cnt_d = cnt_q;
    rem_d = rem_q;  dsr_d = dsr_q;  b_d = b_q;  t_d = t_q;  rb_d = rb_q;
    out_bucket_d = out_bucket_q;  out_status_d = out_status_q;
    rk_we = 1'b0; rk_wa = '0; rk_wd = '0; rk_re = 1'b0; rk_ra = '0;
    wl_we = 1'b0; wl_wa = '0; wl_wd = '0; wl_re = 1'b0; wl_ra = '0;
    lp_we = 1'b0; lp_wa = '0; lp_wd = '0; lp_re = 1'b0; lp_ra = '0;
    dm_we = 1'b0; dm_wa = '0; dm_wd = '0; dm_re = 1'b0; dm_ra = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_re = 1'b0; st_ra = '0;

    unique case (op_i)
      OP_CLR: begin
        rk_we = 1'b1; rk_wa = clr_q; rk_wd = rank_clr;
        wl_we = 1'b1; wl_wa = clr_q; wl_wd = clr_q;
        lp_we = 1'b1; lp_wa = clr_q; lp_wd = clr_q;
        dm_we = 1'b1; dm_wa = clr_q; dm_wd = clr_q;
        st_we = 1'b1; st_wa = clr_q; st_wd = stack_clr;
        clr_d = clr_q + AW'(1);
      end
      OP_CAP: begin
        cmd_d = in_cmd_i;  kh_d = in_key_high_i;  kl_d = in_key_low_i;
        tgt_d = in_target_i;
        crc_d = in_key_low_i[31:0];  data_d = in_key_high_i;
        cnt_d = '0;  first_d = 1'b1;
      end
      OP_CRC: begin
        crc_d  = crc_byte(crc_q, data_q[7:0]);
        data_d = data_q >> 8;
        cnt_d  = cnt_q + 5'd1;
      end
      OP_MODI: begin
        hs_d = crc_q;  div_d = crc_q;  rem_d = '0;  cnt_d = '0;
        dsr_d = first_q ? ac_q : {1'b0, rb_q};
      end
      OP_MOD: begin
        rem_d = (trial >= {1'b0, dsr_q}) ? diff[CW-1:0] : trial[CW-1:0];
        div_d = div_q << 1;
        cnt_d = cnt_q + 5'd1;
      end
      OP_HRD: begin
        rk_re = 1'b1;  rk_ra = AW'(rem_q);
        if (first_q) b_d = AW'(rem_q);
        else t_d = AW'(rem_q);
      end
      OP_LRB: rb_d = rk_rd;
      OP_DEC: begin
        if ((rk_rd == '0) || (rk_rd < rb_q)) begin
          b_d = t_q;  rb_d = rk_rd;
        end
      end
      OP_REH: begin
        crc_d = kl_sum[31:0];  data_d = kh_dif;  cnt_d = '0;  first_d = 1'b0;
      end
      OP_EDM: begin
        dm_re = 1'b1;  dm_ra = b_q;
      end
      OP_ERK: begin
        b_d = dm_rd;  rk_re = 1'b1;  rk_ra = dm_rd;
      end
      OP_TDM: begin
        dm_re = 1'b1;  dm_ra = t_q;
      end
      OP_TRK: begin
        t_d = dm_rd;  rk_re = 1'b1;  rk_ra = dm_rd;
      end
      OP_TCMP: begin
        if (!(rb_q <= rk_rd)) begin
          b_d = t_q;  rb_d = rk_rd;
        end
      end
      OP_LOUT: begin
        out_valid_d = 1'b1;  out_bucket_d = BUCKET_W'(b_q);  out_status_d = 1'b0;
      end
      OP_R1: begin
        rk_re = 1'b1;  rk_ra = AW'(tgt_q);
        lp_re = 1'b1;  lp_ra = AW'(tgt_q);
        wl_re = 1'b1;  wl_ra = AW'(wc_q - CW'(1));
      end
      OP_R2: begin
        out_valid_d = 1'b1;  out_bucket_d = '0;  out_status_d = rm_rej;
        if (!rm_rej) begin
          st_we = 1'b1;  st_wa = AW'(sd_q);      st_wd = AW'(tgt_q);
          wl_we = 1'b1;  wl_wa = lp_rd;          wl_wd = wl_rd;
          lp_we = 1'b1;  lp_wa = wl_rd;          lp_wd = lp_rd;
          dm_we = 1'b1;  dm_wa = AW'(tgt_q);     dm_wd = wl_rd;
          rk_we = 1'b1;  rk_wa = AW'(tgt_q);     rk_wd = AW'(wc_q - CW'(1));
          sd_d = sd_q + CW'(1);
          wc_d = wc_q - CW'(1);
        end
      end
      OP_A1: begin
        st_re = 1'b1;  st_ra = AW'(sd_q - CW'(1));
      end
      OP_A2: begin
        b_d = st_rd;
        wl_re = 1'b1;  wl_ra = AW'(wc_q);
        lp_re = 1'b1;  lp_ra = st_rd;
      end
      OP_A3: begin
        lp_we = 1'b1;  lp_wa = wl_rd;  lp_wd = AW'(wc_q);
        wl_we = 1'b1;  wl_wa = lpb;    wl_wd = b_q;
        rk_we = 1'b1;  rk_wa = b_q;    rk_wd = '0;
        dm_we = 1'b1;  dm_wa = b_q;    dm_wd = b_q;
        wc_d = wc_q + CW'(1);
        sd_d = sd_q - CW'(1);
        out_valid_d = 1'b1;  out_bucket_d = BUCKET_W'(b_q);  out_status_d = 1'b0;
      end
      OP_REJ: begin
        out_valid_d = 1'b1;  out_bucket_d = '0;  out_status_d = 1'b1;
      end
      default: ;
    endcase

    if (cfg_hit) begin
      ac_d  = CW'(ac_new);
      iw_d  = CW'(iw_new);
      wc_d  = CW'(iw_new);
      sd_d  = CW'(ac_new - iw_new);
      clr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_q        <= AcReset;
      iw_q        <= AcReset;
      wc_q        <= AcReset;
      sd_q        <= '0;
      clr_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ac_q        <= ac_d;
      iw_q        <= iw_d;
      wc_q        <= wc_d;
      sd_q        <= sd_d;
      clr_q       <= clr_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  kh_q <= kh_d;  kl_q <= kl_d;  tgt_q <= tgt_d;
    data_q <= data_d;  crc_q <= crc_d;  hs_q <= hs_d;  div_q <= div_d;
    cnt_q <= cnt_d;  rem_q <= rem_d;  dsr_q <= dsr_d;
    b_q <= b_d;  t_q <= t_d;  rb_q <= rb_d;
    out_bucket_q <= out_bucket_d;  out_status_q <= out_status_d;
  end

  chm_ram #(.Width(AW), .Depth(MaxBuckets)) u_rank (
    .clk_i, .we_i(rk_we), .waddr_i(rk_wa), .wdata_i(rk_wd),
    .re_i(rk_re), .raddr_i(rk_ra), .rdata_o(rk_rd));
  chm_ram #(.Width(AW), .Depth(MaxBuckets)) u_work (
    .clk_i, .we_i(wl_we), .waddr_i(wl_wa), .wdata_i(wl_wd),
    .re_i(wl_re), .raddr_i(wl_ra), .rdata_o(wl_rd));
  chm_ram #(.Width(AW), .Depth(MaxBuckets)) u_lpos (
    .clk_i, .we_i(lp_we), .waddr_i(lp_wa), .wdata_i(lp_wd),
    .re_i(lp_re), .raddr_i(lp_ra), .rdata_o(lp_rd));
  chm_ram #(.Width(AW), .Depth(MaxBuckets)) u_diag (
    .clk_i, .we_i(dm_we), .waddr_i(dm_wa), .wdata_i(dm_wd),
    .re_i(dm_re), .raddr_i(dm_ra), .rdata_o(dm_rd));
  chm_ram #(.Width(AW), .Depth(MaxBuckets)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd),
    .re_i(st_re), .raddr_i(st_ra), .rdata_o(st_rd));

  assign out_valid_o  = out_valid_q;
  assign out_bucket_o = out_bucket_q;
  assign out_status_o = out_status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wc_q + sd_q) == ac_q)
    else $error("Working and reserved counts do not add up.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q != '0 && iw_q <= ac_q)
    else $error("Bucket counts out of range.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_MOD) |-> dsr_q != '0)
    else $error("Modulo by zero.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_LOUT) |-> rb_q == '0)
    else $error("Lookup ended on a removed bucket.");

endmodule
